@@ rtl/core/csu_pkg.sv @@
// Package for the sound unit: item codes, register offsets, tables and shared types.
package csu_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam logic [4:0] REG_P0_CTRL  = 5'd0;
  localparam logic [4:0] REG_P0_SWEEP = 5'd1;
  localparam logic [4:0] REG_P0_LO    = 5'd2;
  localparam logic [4:0] REG_P0_HI    = 5'd3;
  localparam logic [4:0] REG_P1_CTRL  = 5'd4;
  localparam logic [4:0] REG_P1_SWEEP = 5'd5;
  localparam logic [4:0] REG_P1_LO    = 5'd6;
  localparam logic [4:0] REG_P1_HI    = 5'd7;
  localparam logic [4:0] REG_TRI_LIN  = 5'd8;
  localparam logic [4:0] REG_TRI_LO   = 5'd10;
  localparam logic [4:0] REG_TRI_HI   = 5'd11;
  localparam logic [4:0] REG_NZ_CTRL  = 5'd12;
  localparam logic [4:0] REG_NZ_PER   = 5'd14;
  localparam logic [4:0] REG_NZ_LEN   = 5'd15;
  localparam logic [4:0] REG_STATUS   = 5'd21;
  localparam logic [4:0] REG_FRAME    = 5'd23;

  localparam logic [15:0] FC_Q1   = 16'd7457;
  localparam logic [15:0] FC_H1   = 16'd14913;
  localparam logic [15:0] FC_Q3   = 16'd22371;
  localparam logic [15:0] FC_4END = 16'd29829;
  localparam logic [15:0] FC_4WR  = 16'd29830;
  localparam logic [15:0] FC_5END = 16'd37281;
  localparam logic [15:0] FC_5WR  = 16'd37282;

  localparam logic [9:0] W_PULSE = 10'd493;
  localparam logic [9:0] W_TRI   = 10'd558;
  localparam logic [9:0] W_NOISE = 10'd324;

  // one pulse channel
  typedef struct packed {
    logic [10:0] timer;
    logic [10:0] period;
    logic [1:0]  duty;
    logic [2:0]  step;
    logic [7:0]  length;
    logic        en, halt, cvol, start, swen, neg, swrld;
    logic [3:0]  volume;
    logic [3:0]  decay;
    logic [3:0]  env_div;
    logic [2:0]  sw_shift;
    logic [2:0]  sw_per;
    logic [2:0]  sw_div;
  } pulse_t;

  // levels handed from the state core to the mixer
  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
    logic [3:0] pa, pb, tr, nz;
  } levels_t;

  function automatic logic [7:0] len_lut(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'd10;   5'd1: r = 8'd254; 5'd2: r = 8'd20;  5'd3: r = 8'd2;
      5'd4: r = 8'd40;   5'd5: r = 8'd4;   5'd6: r = 8'd80;  5'd7: r = 8'd6;
      5'd8: r = 8'd160;  5'd9: r = 8'd8;   5'd10: r = 8'd60; 5'd11: r = 8'd10;
      5'd12: r = 8'd14;  5'd13: r = 8'd12; 5'd14: r = 8'd26; 5'd15: r = 8'd14;
      5'd16: r = 8'd12;  5'd17: r = 8'd16; 5'd18: r = 8'd24; 5'd19: r = 8'd18;
      5'd20: r = 8'd48;  5'd21: r = 8'd20; 5'd22: r = 8'd96; 5'd23: r = 8'd22;
      5'd24: r = 8'd192; 5'd25: r = 8'd24; 5'd26: r = 8'd72; 5'd27: r = 8'd26;
      5'd28: r = 8'd16;  5'd29: r = 8'd28; 5'd30: r = 8'd32; default: r = 8'd30;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] noise_lut(input logic [3:0] i);
    logic [11:0] r;
    case (i)
      4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;    4'd3: r = 12'd32;
      4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;   4'd7: r = 12'd160;
      4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380;  4'd11: r = 12'd508;
      4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] duty_lut(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0: r = 8'h02;
      2'd1: r = 8'h06;
      2'd2: r = 8'h1E;
      default: r = 8'hF9;
    endcase
    return r;
  endfunction

  // sweep target, 12 bits so overflow above 0x7FF shows
  function automatic logic [11:0] sweep_tgt(input pulse_t p, input logic ones);
    logic [11:0] chg;
    chg = {1'b0, p.period >> p.sw_shift};
    if (!p.neg) return {1'b0, p.period} + chg;
    return {1'b0, p.period} - chg - {11'd0, ones};
  endfunction

  function automatic logic pulse_mute(input pulse_t p, input logic ones);
    logic [11:0] t;
    t = sweep_tgt(p, ones);
    return (p.period < 11'd8) || (!p.neg && (t > 12'h7FF));
  endfunction

endpackage

@@ rtl/core/csu_core.sv @@
// Channel and frame sequencer state, updated once per accepted beat; yields channel levels.
module csu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          mode_i,
  input  logic [4:0]          off_i,
  input  logic [7:0]          data_i,
  output csu_pkg::levels_t    lv_o
);

  csu_pkg::pulse_t p_q [2];
  csu_pkg::pulse_t p_d [2];
  logic [10:0] tt_q, tt_d, tp_q, tp_d;
  logic [4:0]  ts_q, ts_d;
  logic [7:0]  tl_q, tl_d;
  logic [6:0]  tlin_q, tlin_d, trl_q, trl_d;
  logic        ten_q, ten_d, tctl_q, tctl_d, trf_q, trf_d;
  logic [11:0] nt_q, nt_d, np_q, np_d;
  logic [14:0] ns_q, ns_d;
  logic [7:0]  nl_q, nl_d;
  logic        nen_q, nen_d, nhalt_q, nhalt_d, ncv_q, ncv_d, nst_q, nst_d, nmd_q, nmd_d;
  logic [3:0]  nv_q, nv_d, nd_q, nd_d, ndiv_q, ndiv_d;
  logic [15:0] fc_q, fc_d;
  logic        f5_q, f5_d, finh_q, finh_d, firq_q, firq_d, ftog_q, ftog_d;
  logic [7:0]  rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q[0] <= '0; p_q[1] <= '0;
      tt_q <= '0; tp_q <= '0; ts_q <= '0; tl_q <= '0; tlin_q <= '0; trl_q <= '0;
      ten_q <= 1'b0; tctl_q <= 1'b0; trf_q <= 1'b0;
      nt_q <= '0; np_q <= '0; ns_q <= 15'd1; nl_q <= '0;
      nen_q <= 1'b0; nhalt_q <= 1'b0; ncv_q <= 1'b0; nst_q <= 1'b0; nmd_q <= 1'b0;
      nv_q <= '0; nd_q <= '0; ndiv_q <= '0;
      fc_q <= '0; f5_q <= 1'b0; finh_q <= 1'b0; firq_q <= 1'b0; ftog_q <= 1'b0;
    end else if (step_i) begin
      p_q[0] <= p_d[0]; p_q[1] <= p_d[1];
      tt_q <= tt_d; tp_q <= tp_d; ts_q <= ts_d; tl_q <= tl_d; tlin_q <= tlin_d;
      trl_q <= trl_d; ten_q <= ten_d; tctl_q <= tctl_d; trf_q <= trf_d;
      nt_q <= nt_d; np_q <= np_d; ns_q <= ns_d; nl_q <= nl_d;
      nen_q <= nen_d; nhalt_q <= nhalt_d; ncv_q <= ncv_d; nst_q <= nst_d; nmd_q <= nmd_d;
      nv_q <= nv_d; nd_q <= nd_d; ndiv_q <= ndiv_d;
      fc_q <= fc_d; f5_q <= f5_d; finh_q <= finh_d; firq_q <= firq_d; ftog_q <= ftog_d;
    end
  end

  always_comb begin
    logic qf, hf;
    logic [1:0] ch;
    logic fb;
    logic [11:0] tg;
    p_d[0] = p_q[0]; p_d[1] = p_q[1];
    tt_d = tt_q; tp_d = tp_q; ts_d = ts_q; tl_d = tl_q; tlin_d = tlin_q; trl_d = trl_q;
    ten_d = ten_q; tctl_d = tctl_q; trf_d = trf_q;
    nt_d = nt_q; np_d = np_q; ns_d = ns_q; nl_d = nl_q;
    nen_d = nen_q; nhalt_d = nhalt_q; ncv_d = ncv_q; nst_d = nst_q; nmd_d = nmd_q;
    nv_d = nv_q; nd_d = nd_q; ndiv_d = ndiv_q;
    fc_d = fc_q; f5_d = f5_q; finh_d = finh_q; firq_d = firq_q; ftog_d = ftog_q;
    qf = 1'b0; hf = 1'b0;
    rd = '0;
    ch = '0;
    fb = 1'b0;
    tg = '0;

    case (csu_pkg::mode_e'(mode_i))
      csu_pkg::MODE_TICK: begin
        if (tt_q == '0) begin
          tt_d = tp_q;
          if (tl_q != '0 && tlin_q != '0) ts_d = ts_q + 5'd1;
        end else begin
          tt_d = tt_q - 11'd1;
        end
        if (nt_q == '0) begin
          nt_d = np_q;
          fb = ns_q[0] ^ (nmd_q ? ns_q[6] : ns_q[1]);
          ns_d = {fb, ns_q[14:1]};
        end else begin
          nt_d = nt_q - 12'd1;
        end
        ftog_d = !ftog_q;
        if (ftog_d) begin
          for (int c = 0; c < 2; c++) begin
            if (p_q[c].timer == '0) begin
              p_d[c].timer = p_q[c].period;
              p_d[c].step = p_q[c].step + 3'd1;
            end else begin
              p_d[c].timer = p_q[c].timer - 11'd1;
            end
          end
        end
        fc_d = fc_q + 16'd1;
        if (!f5_q) begin
          if (fc_d == csu_pkg::FC_Q1 || fc_d == csu_pkg::FC_Q3) qf = 1'b1;
          else if (fc_d == csu_pkg::FC_H1) begin qf = 1'b1; hf = 1'b1; end
          else if (fc_d == csu_pkg::FC_4END) begin
            qf = 1'b1; hf = 1'b1;
            if (!finh_q) firq_d = 1'b1;
          end else if (fc_d == csu_pkg::FC_4WR) fc_d = '0;
        end else begin
          if (fc_d == csu_pkg::FC_Q1 || fc_d == csu_pkg::FC_Q3) qf = 1'b1;
          else if (fc_d == csu_pkg::FC_H1 || fc_d == csu_pkg::FC_5END) begin
            qf = 1'b1; hf = 1'b1;
          end else if (fc_d == csu_pkg::FC_5WR) fc_d = '0;
        end
      end
      csu_pkg::MODE_WRITE: begin
        ch = (off_i >= csu_pkg::REG_P1_CTRL && off_i <= csu_pkg::REG_P1_HI) ? 2'd1 : 2'd0;
        case (off_i)
          csu_pkg::REG_P0_CTRL, csu_pkg::REG_P1_CTRL: begin
            p_d[ch[0]].duty = data_i[7:6];
            p_d[ch[0]].halt = data_i[5];
            p_d[ch[0]].cvol = data_i[4];
            p_d[ch[0]].volume = data_i[3:0];
          end
          csu_pkg::REG_P0_SWEEP, csu_pkg::REG_P1_SWEEP: begin
            p_d[ch[0]].swen = data_i[7];
            p_d[ch[0]].neg = data_i[3];
            p_d[ch[0]].swrld = 1'b1;
            p_d[ch[0]].sw_per = data_i[6:4];
            p_d[ch[0]].sw_shift = data_i[2:0];
          end
          csu_pkg::REG_P0_LO, csu_pkg::REG_P1_LO:
            p_d[ch[0]].period[7:0] = data_i;
          csu_pkg::REG_P0_HI, csu_pkg::REG_P1_HI: begin
            p_d[ch[0]].period[10:8] = data_i[2:0];
            if (p_q[ch[0]].en) p_d[ch[0]].length = csu_pkg::len_lut(data_i[7:3]);
            p_d[ch[0]].step = '0;
            p_d[ch[0]].start = 1'b1;
          end
          csu_pkg::REG_TRI_LIN: begin
            tctl_d = data_i[7];
            trl_d = data_i[6:0];
          end
          csu_pkg::REG_TRI_LO: tp_d[7:0] = data_i;
          csu_pkg::REG_TRI_HI: begin
            tp_d[10:8] = data_i[2:0];
            if (ten_q) tl_d = csu_pkg::len_lut(data_i[7:3]);
            trf_d = 1'b1;
          end
          csu_pkg::REG_NZ_CTRL: begin
            nhalt_d = data_i[5];
            ncv_d = data_i[4];
            nv_d = data_i[3:0];
          end
          csu_pkg::REG_NZ_PER: begin
            nmd_d = data_i[7];
            np_d = csu_pkg::noise_lut(data_i[3:0]);
          end
          csu_pkg::REG_NZ_LEN: begin
            if (nen_q) nl_d = csu_pkg::len_lut(data_i[7:3]);
            nst_d = 1'b1;
          end
          csu_pkg::REG_STATUS: begin
            p_d[0].en = data_i[0]; p_d[1].en = data_i[1];
            ten_d = data_i[2]; nen_d = data_i[3];
            if (!data_i[0]) p_d[0].length = '0;
            if (!data_i[1]) p_d[1].length = '0;
            if (!data_i[2]) tl_d = '0;
            if (!data_i[3]) nl_d = '0;
          end
          csu_pkg::REG_FRAME: begin
            f5_d = data_i[7];
            finh_d = data_i[6];
            if (data_i[6]) firq_d = 1'b0;
            fc_d = '0;
            if (data_i[7]) begin qf = 1'b1; hf = 1'b1; end
          end
          default: ;
        endcase
      end
      csu_pkg::MODE_READ: begin
        rd = {1'b0, firq_q, 2'b00, nl_q != '0, tl_q != '0,
              p_q[1].length != '0, p_q[0].length != '0};
        firq_d = 1'b0;
      end
      default: ;
    endcase

    // quarter frame: envelopes and linear counter (write effects already applied)
    if (qf) begin
      for (int c = 0; c < 2; c++) begin
        if (p_d[c].start) begin
          p_d[c].start = 1'b0; p_d[c].decay = 4'd15; p_d[c].env_div = p_d[c].volume;
        end else if (p_d[c].env_div == '0) begin
          p_d[c].env_div = p_d[c].volume;
          if (p_d[c].decay != '0) p_d[c].decay = p_d[c].decay - 4'd1;
          else if (p_d[c].halt) p_d[c].decay = 4'd15;
        end else begin
          p_d[c].env_div = p_d[c].env_div - 4'd1;
        end
      end
      if (nst_d) begin
        nst_d = 1'b0; nd_d = 4'd15; ndiv_d = nv_d;
      end else if (ndiv_d == '0) begin
        ndiv_d = nv_d;
        if (nd_d != '0) nd_d = nd_d - 4'd1;
        else if (nhalt_d) nd_d = 4'd15;
      end else begin
        ndiv_d = ndiv_d - 4'd1;
      end
      if (trf_d) tlin_d = trl_d;
      else if (tlin_d != '0) tlin_d = tlin_d - 7'd1;
      if (!tctl_d) trf_d = 1'b0;
    end
    // half frame: length counters and sweep
    if (hf) begin
      for (int c = 0; c < 2; c++) begin
        if (!p_d[c].halt && p_d[c].length != '0) p_d[c].length = p_d[c].length - 8'd1;
        tg = csu_pkg::sweep_tgt(p_d[c], c == 0);
        if (p_d[c].sw_div == '0 && p_d[c].swen && p_d[c].sw_shift != '0 &&
            !csu_pkg::pulse_mute(p_d[c], c == 0))
          p_d[c].period = tg[10:0];
        if (p_d[c].sw_div == '0 || p_d[c].swrld) begin
          p_d[c].sw_div = p_d[c].sw_per;
          p_d[c].swrld = 1'b0;
        end else begin
          p_d[c].sw_div = p_d[c].sw_div - 3'd1;
        end
      end
      if (!tctl_d && tl_d != '0) tl_d = tl_d - 8'd1;
      if (!nhalt_d && nl_d != '0) nl_d = nl_d - 8'd1;
    end
  end

  // levels after the item
  always_comb begin
    logic [3:0] lv [2];
    logic [7:0] dt;
    for (int c = 0; c < 2; c++) begin
      dt = csu_pkg::duty_lut(p_d[c].duty);
      if (!p_d[c].en || p_d[c].length == '0 || csu_pkg::pulse_mute(p_d[c], c == 0) ||
          !dt[p_d[c].step])
        lv[c] = '0;
      else
        lv[c] = p_d[c].cvol ? p_d[c].volume : p_d[c].decay;
    end
    lv_o.rd = rd;
    lv_o.irq = firq_d;
    lv_o.pa = lv[0];
    lv_o.pb = lv[1];
    lv_o.tr = !ten_d ? 4'd0 : (ts_d[4] ? ts_d[3:0] : ~ts_d[3:0]);
    lv_o.nz = (nen_d && nl_d != '0 && !ns_d[0]) ? (ncv_d ? nv_d : nd_d) : 4'd0;
  end

endmodule

@@ rtl/core/csu_mix.sv @@
// Result register with ready/valid handshake and the weighted channel mix.
module csu_mix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  csu_pkg::levels_t lv_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             free_o,
  output logic [39:0]      out_data_o
);

  csu_pkg::levels_t r_q;
  logic             v_q;
  logic [14:0]      mix;

  assign free_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (free_o) v_q <= load_i;
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) r_q <= lv_i;
  end

  always_comb begin
    logic [19:0] s;
    s = 20'(csu_pkg::W_PULSE * ({1'b0, r_q.pa} + {1'b0, r_q.pb}))
      + 20'(csu_pkg::W_TRI * r_q.tr) + 20'(csu_pkg::W_NOISE * r_q.nz);
    mix = s[14:0];
  end

  assign out_valid_o = v_q;
  assign out_data_o = {mix, r_q.nz, r_q.tr, r_q.pb, r_q.pa, r_q.irq, r_q.rd};

endmodule

@@ rtl/core/console_sound_unit.sv @@
// Sound unit top level: two pulse, triangle and noise channels, frame sequencer, mixer.
// One beat per clock while s_axis_tready is high: tick, register write or status read.
// The state update is combinational over the state registers, so each accepted beat
// updates state at one edge and its result is loaded into the output register at that
// same edge; s_axis_tready stays high while that register is empty or being drained.
module console_sound_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // mode[1:0], reg_offset[6:2], write_data[14:7], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // read_data[7:0], irq_pending[8], pulse_a[12:9],
                                     // pulse_b[16:13], triangle[20:17], noise[24:21],
                                     // mixed_level[39:25]
);

  csu_pkg::levels_t lv;
  logic             free;
  logic             acc;

  assign s_axis_tready = free;
  assign acc = s_axis_tvalid && free;

  csu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (acc),
    .mode_i (s_axis_tdata[1:0]),
    .off_i  (s_axis_tdata[6:2]),
    .data_i (s_axis_tdata[14:7]),
    .lv_o   (lv)
  );

  csu_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (acc),
    .lv_i        (lv),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .free_o      (free),
    .out_data_o  (m_axis_tdata)
  );

endmodule
